### rtl/vrrf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vrrf_pkg;

    localparam int CAPACITY     = 1024;
    localparam int MAX_RECORD   = 64;
    localparam int HEADER_BYTES = 4;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int FREE_W = $clog2(CAPACITY + 1);
    localparam int SUM_W  = ((ADDR_W > 8) ? ADDR_W : 8) + 1;

    // Request kinds
    localparam logic [1:0] REQ_PUSH  = 2'd0;
    localparam logic [1:0] REQ_POP   = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;
    localparam logic [1:0] STAT_SEQ   = 2'd3;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_PUSH,
        OP_PUSH_DATA,
        OP_CLEAR,
        OP_SEQ_ERR,
        OP_POP_EMPTY,
        OP_POP_HDR,
        OP_POP_LEN,
        OP_POP_BYTE
    } dp_op_t;

    typedef struct packed {
        logic   latch_in;
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic       out_free;
        logic [1:0] req;
        logic       push_hdr;
        logic       pop_empty;
        logic       push_open;
        logic       pop_zero;
        logic       pop_last;
    } dp_stat_t;

    // Advance a store pointer by k bytes, wrapping at the store end (sum below twice capacity)
    function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] p,
                                                   input logic [7:0] k);
        logic [SUM_W-1:0] s;
        s = SUM_W'(p) + SUM_W'(k);
        if (s >= SUM_W'(CAPACITY))
        begin
            s = s - SUM_W'(CAPACITY);
        end
        return s[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

### rtl/vrrf_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module vrrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // hold read data until the next read
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/vrrf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module vrrf_ctrl
    import vrrf_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_PUSH_DATA,
        S_POP_LEN,
        S_POP_BYTE
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cmd.latch_in = 1'b0;
        cmd.op       = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.out_free)
                begin
                    case (stat.req)
                        REQ_PUSH:
                        begin
                            cmd.op     = OP_PUSH;
                            state_next = stat.push_hdr ? S_PUSH_DATA : S_IDLE;
                        end
                        REQ_POP:
                        begin
                            if (stat.pop_empty)
                            begin
                                cmd.op     = OP_POP_EMPTY;
                                state_next = S_IDLE;
                            end
                            else if (stat.push_open)
                            begin
                                cmd.op     = OP_SEQ_ERR;
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                cmd.op     = OP_POP_HDR;
                                state_next = S_POP_LEN;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            cmd.op     = OP_CLEAR;
                            state_next = S_IDLE;
                        end
                        default:
                        begin
                            cmd.op     = OP_SEQ_ERR;
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_PUSH_DATA:
            begin
                cmd.op     = OP_PUSH_DATA;
                state_next = S_IDLE;
            end
            S_POP_LEN:
            begin
                cmd.op     = OP_POP_LEN;
                state_next = stat.pop_zero ? S_IDLE : S_POP_BYTE;
            end
            S_POP_BYTE:
            begin
                if (stat.out_free)
                begin
                    cmd.op = OP_POP_BYTE;
                    if (stat.pop_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### rtl/vrrf_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module vrrf_datapath
    import vrrf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [23:0] s_tdata,
    input  wire logic [2:0]  s_tuser,
    input  wire dp_cmd_t     cmd,
    output dp_stat_t         stat,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,
    output logic [2:0]       m_tuser,
    output logic             m_tlast
);

    // latched request
    logic [1:0] in_req_reg;
    logic [7:0] in_data_reg;
    logic       in_first_reg;
    logic [6:0] in_len_reg;
    logic [6:0] in_limit_reg;

    // store control state
    logic [ADDR_W-1:0] rp_reg, rp_next;
    logic [ADDR_W-1:0] wp_reg, wp_next;
    logic [FREE_W-1:0] free_reg, free_next;
    logic [6:0]        rem_reg, rem_next;
    logic              disc_reg, disc_next;
    logic [ADDR_W-1:0] pp_reg, pp_next;
    logic [6:0]        cnt_reg, cnt_next;

    // output register
    logic        ovalid_reg, ovalid_next;
    logic [7:0]  ob_reg, ob_next;
    logic        obv_reg, obv_next;
    logic        olast_reg, olast_next;
    logic [1:0]  ost_reg, ost_next;
    logic [10:0] ofree_reg, ofree_next;
    logic        oempty_reg, oempty_next;
    logic        load_out;

    // store port
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    logic        push_open;
    logic        len_bad;
    logic        too_big;
    logic        push_hdr;
    logic [6:0]  hdr_len;
    logic [6:0]  pop_n;
    logic [31:0] free_add;
    logic [31:0] free32;

    vrrf_ram #(
        .WIDTH (8),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign push_open = (rem_reg != 7'd0) && !disc_reg;
    assign len_bad   = (in_len_reg == 7'd0) || (in_len_reg > 7'(MAX_RECORD));
    assign too_big   = (32'(in_len_reg) + 32'(HEADER_BYTES)) > 32'(free_reg);
    assign push_hdr  = in_first_reg && !push_open && !len_bad && !too_big;

    // header byte 0 holds the length; clamp as a guard
    assign hdr_len  = (ram_rdata > 8'(MAX_RECORD)) ? 7'(MAX_RECORD) : ram_rdata[6:0];
    assign pop_n    = (hdr_len < in_limit_reg) ? hdr_len : in_limit_reg;
    assign free_add = 32'(free_reg) + 32'(hdr_len) + 32'(HEADER_BYTES);
    assign free32   = 32'(free_next);

    assign stat.out_free  = !ovalid_reg || m_tready;
    assign stat.req       = in_req_reg;
    assign stat.push_hdr  = push_hdr;
    assign stat.pop_empty = (free_reg >= FREE_W'(CAPACITY));
    assign stat.push_open = push_open;
    assign stat.pop_zero  = (pop_n == 7'd0);
    assign stat.pop_last  = (cnt_reg == 7'd1);

    always_comb
    begin
        rp_next    = rp_reg;
        wp_next    = wp_reg;
        free_next  = free_reg;
        rem_next   = rem_reg;
        disc_next  = disc_reg;
        pp_next    = pp_reg;
        cnt_next   = cnt_reg;
        ram_we     = 1'b0;
        ram_waddr  = wp_reg;
        ram_wdata  = in_data_reg;
        ram_re     = 1'b0;
        ram_raddr  = pp_reg;
        load_out   = 1'b0;
        ob_next    = ob_reg;
        obv_next   = obv_reg;
        olast_next = olast_reg;
        ost_next   = ost_reg;
        case (cmd.op)
            OP_PUSH:
            begin
                load_out   = 1'b1;
                ob_next    = 8'd0;
                obv_next   = 1'b0;
                olast_next = 1'b1;
                ost_next   = STAT_OK;
                if (in_first_reg)
                begin
                    if (push_open)
                    begin
                        ost_next = STAT_SEQ;
                    end
                    else if (len_bad || too_big)
                    begin
                        ost_next  = len_bad ? STAT_SEQ : STAT_FULL;
                        rem_next  = (in_len_reg > 7'd1) ? (in_len_reg - 7'd1) : 7'd0;
                        disc_next = (in_len_reg > 7'd1);
                    end
                    else
                    begin
                        // write the length header now, the data byte next cycle
                        ram_we    = 1'b1;
                        ram_wdata = 8'(in_len_reg);
                        wp_next   = wrap_add(wp_reg, 8'(HEADER_BYTES));
                        free_next = free_reg - FREE_W'(32'(in_len_reg) + 32'(HEADER_BYTES));
                        rem_next  = in_len_reg - 7'd1;
                        disc_next = 1'b0;
                    end
                end
                else if (rem_reg == 7'd0)
                begin
                    ost_next = STAT_SEQ;
                end
                else
                begin
                    rem_next = rem_reg - 7'd1;
                    if (disc_reg)
                    begin
                        ost_next = STAT_FULL;
                        if (rem_reg == 7'd1)
                        begin
                            disc_next = 1'b0;
                        end
                    end
                    else
                    begin
                        ram_we  = 1'b1;
                        wp_next = wrap_add(wp_reg, 8'd1);
                    end
                end
            end
            OP_PUSH_DATA:
            begin
                ram_we  = 1'b1;
                wp_next = wrap_add(wp_reg, 8'd1);
            end
            OP_CLEAR:
            begin
                rp_next    = '0;
                wp_next    = '0;
                free_next  = FREE_W'(CAPACITY);
                rem_next   = 7'd0;
                disc_next  = 1'b0;
                load_out   = 1'b1;
                ob_next    = 8'd0;
                obv_next   = 1'b0;
                olast_next = 1'b1;
                ost_next   = STAT_OK;
            end
            OP_SEQ_ERR,
            OP_POP_EMPTY:
            begin
                load_out   = 1'b1;
                ob_next    = 8'd0;
                obv_next   = 1'b0;
                olast_next = 1'b1;
                ost_next   = (cmd.op == OP_POP_EMPTY) ? STAT_EMPTY : STAT_SEQ;
            end
            OP_POP_HDR:
            begin
                ram_re    = 1'b1;
                ram_raddr = rp_reg;
            end
            OP_POP_LEN:
            begin
                free_next = (free_add > 32'(CAPACITY)) ? FREE_W'(CAPACITY)
                                                        : FREE_W'(free_add);
                rp_next   = wrap_add(rp_reg, 8'(32'(hdr_len) + 32'(HEADER_BYTES)));
                cnt_next  = pop_n;
                if (pop_n == 7'd0)
                begin
                    load_out   = 1'b1;
                    ob_next    = 8'd0;
                    obv_next   = 1'b0;
                    olast_next = 1'b1;
                    ost_next   = STAT_OK;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = wrap_add(rp_reg, 8'(HEADER_BYTES));
                    pp_next   = wrap_add(ram_raddr, 8'd1);
                end
            end
            OP_POP_BYTE:
            begin
                load_out   = 1'b1;
                ob_next    = ram_rdata;
                obv_next   = 1'b1;
                olast_next = (cnt_reg == 7'd1);
                ost_next   = STAT_OK;
                cnt_next   = cnt_reg - 7'd1;
                if (cnt_reg != 7'd1)
                begin
                    ram_re  = 1'b1;
                    pp_next = wrap_add(pp_reg, 8'd1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        ofree_next  = ofree_reg;
        oempty_next = oempty_reg;
        if (load_out)
        begin
            ofree_next  = free32[10:0];
            oempty_next = (free_next >= FREE_W'(CAPACITY));
        end
        if (load_out)
        begin
            ovalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            ovalid_next = 1'b0;
        end
        else
        begin
            ovalid_next = ovalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg     <= '0;
            wp_reg     <= '0;
            free_reg   <= FREE_W'(CAPACITY);
            rem_reg    <= 7'd0;
            disc_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            rp_reg     <= rp_next;
            wp_reg     <= wp_next;
            free_reg   <= free_next;
            rem_reg    <= rem_next;
            disc_reg   <= disc_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            in_req_reg   <= s_tuser[1:0];
            in_first_reg <= s_tuser[2];
            in_data_reg  <= s_tdata[7:0];
            in_len_reg   <= s_tdata[14:8];
            in_limit_reg <= s_tdata[21:15];
        end
        pp_reg     <= pp_next;
        cnt_reg    <= cnt_next;
        ob_reg     <= ob_next;
        obv_reg    <= obv_next;
        olast_reg  <= olast_next;
        ost_reg    <= ost_next;
        ofree_reg  <= ofree_next;
        oempty_reg <= oempty_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {4'd0, oempty_reg, ofree_reg, ob_reg};
    assign m_tuser  = {ost_reg, obv_reg};
    assign m_tlast  = olast_reg;

    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= FREE_W'(CAPACITY))
        else $error("free count above capacity");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (free_reg == FREE_W'(CAPACITY)) |-> (rp_reg == wp_reg))
        else $error("empty store with read and write pointers apart");

    a_disc_rem: assert property (@(posedge clk) disable iff (!rst_n)
        disc_reg |-> (rem_reg != 7'd0))
        else $error("dropping a record with no bytes left to drop");

endmodule

`default_nettype wire

### rtl/variable_record_ring_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

// Ring FIFO of variable-length byte records in a 1024-byte store. Each record
// takes a 4-byte length header plus its data, and the header counts against
// capacity. Send a record as push beats (req_type 0), one data byte a beat,
// with first_byte and record_len on the opening beat; a record that does not
// fit is refused whole and its remaining beats are dropped with status full.
// A pop beat (req_type 1) returns up to out_limit bytes of the oldest record,
// one result beat a byte with tlast on the final one (a single beat with no
// byte if none are returned), and frees the whole record; an empty store
// answers with one beat of status empty, and a pop while a pushed record is
// still open is answered out of sequence. Clear (req_type 2) empties the
// store. Every other beat gives one result beat. One request is in work at a
// time. An opening beat that is stored writes the header and then the first
// byte, as they share the single write port; a pop reads the header through
// the registered read of the store, then one byte per result beat. A receiver
// that holds off stalls this work while a finished result beat waits. The
// result register lets the next request be taken while a finished result beat
// waits. No clearing pass runs after reset: the store is read only where a
// push has written it.
module variable_record_ring_fifo
    import vrrf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,  // data_byte[7:0], record_len[14:8], out_limit[21:15]
    input  wire logic [2:0]  s_tuser,  // req_type[1:0], first_byte[2]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,  // out_byte[7:0], free_bytes[18:8], is_empty[19]
    output logic [2:0]       m_tuser,  // byte_valid[0], status[2:1]
    output logic             m_tlast   // last
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequence each request
    vrrf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // hold pointers, free count, the byte store and the result register
    vrrf_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
